// File: rtl/core/wsfr_pkg.sv
// Package for the WebSocket frame receiver: parse phases, opcodes, result kinds,
// error codes and the result structure shared by the parser, output stage and top level.
// Depends on nothing.
package wsfr_pkg;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT16,
        PH_EXT64,
        PH_MASK,
        PH_PAYLOAD
    } phase_t;

    localparam logic [3:0] OP_CONT   = 4'd0;
    localparam logic [3:0] OP_TEXT   = 4'd1;
    localparam logic [3:0] OP_BINARY = 4'd2;
    localparam logic [3:0] OP_CLOSE  = 4'd8;
    localparam logic [3:0] OP_PING   = 4'd9;
    localparam logic [3:0] OP_PONG   = 4'd10;

    localparam logic [2:0] KIND_DATA         = 3'd0;
    localparam logic [2:0] KIND_DATA_END     = 3'd1;
    localparam logic [2:0] KIND_PING         = 3'd2;
    localparam logic [2:0] KIND_PING_EMPTY   = 3'd3;
    localparam logic [2:0] KIND_CLOSE_STATUS = 3'd4;
    localparam logic [2:0] KIND_CLOSE_REASON = 3'd5;
    localparam logic [2:0] KIND_ERROR        = 3'd6;

    localparam logic [3:0] ERR_NO_MASK        = 4'd1;
    localparam logic [3:0] ERR_RESERVED       = 4'd2;
    localparam logic [3:0] ERR_CTRL_TOO_LONG  = 4'd3;
    localparam logic [3:0] ERR_CTRL_FRAGMENT  = 4'd4;
    localparam logic [3:0] ERR_CLOSE_LEN_ONE  = 4'd5;
    localparam logic [3:0] ERR_UNKNOWN_OPCODE = 4'd6;
    localparam logic [3:0] ERR_ORPHAN_CONT    = 4'd7;
    localparam logic [3:0] ERR_TOO_BIG        = 4'd8;

    localparam logic [6:0]  LEN7_EXT16      = 7'd126;
    localparam logic [6:0]  LEN7_EXT64      = 7'd127;
    localparam logic [6:0]  CTRL_MAX_LEN    = 7'd125;
    localparam logic [15:0] STATUS_NO_CODE  = 16'd1005;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [2:0]  kind;
        logic        last_flag;
        logic        binary_flag;
        logic [15:0] close_status;
        logic [3:0]  error_code;
    } result_t;

endpackage

// File: rtl/core/wsfr_parser.sv
// Frame parser: header, length and mask key registers with the next-state logic that
// unmasks payload bytes and forms at most one result per accepted byte. Uses wsfr_pkg.
module wsfr_parser
    import wsfr_pkg::*;
#(
    parameter int LEN_W = 32
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_accept,
    input  logic [7:0]       in_byte,
    input  logic [LEN_W-1:0] max_len,
    output logic             res_valid,
    output result_t          res
);

    phase_t      phase_reg, phase_next;
    logic        fin_reg, fin_next;
    logic [2:0]  rsv_reg, rsv_next;
    logic [3:0]  opcode_reg, opcode_next;
    logic        mask_bit_reg, mask_bit_next;
    logic [63:0] len_reg, len_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [31:0] key_reg, key_next;
    logic [1:0]  kidx_reg, kidx_next;
    logic [1:0]  cpos_reg, cpos_next;
    logic        active_reg, active_next;
    logic        binary_reg, binary_next;
    logic [LEN_W-1:0] total_reg, total_next;
    logic [7:0]  close_hi_reg, close_hi_next;
    logic        halted_reg, halted_next;

    logic [LEN_W-1:0] remain;
    logic             too_big;
    logic             ctrl_too_long;
    logic [7:0]       key_byte;
    logic [7:0]       plain;
    logic             last_byte;

    assign remain = (max_len > total_reg) ? (max_len - total_reg) : '0;
    assign too_big = (len_reg[63:LEN_W] != '0) || (len_reg[LEN_W-1:0] > remain);
    assign ctrl_too_long = (len_reg[63:7] != '0) || (len_reg[6:0] > CTRL_MAX_LEN);
    assign last_byte = (len_reg == 64'd1);

    always_comb begin
        case (kidx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    assign plain = in_byte ^ key_byte;

    always_comb begin
        phase_next    = phase_reg;
        fin_next      = fin_reg;
        rsv_next      = rsv_reg;
        opcode_next   = opcode_reg;
        mask_bit_next = mask_bit_reg;
        len_next      = len_reg;
        cnt_next      = cnt_reg;
        key_next      = key_reg;
        kidx_next     = kidx_reg;
        cpos_next     = cpos_reg;
        active_next   = active_reg;
        binary_next   = binary_reg;
        total_next    = total_reg;
        close_hi_next = close_hi_reg;
        halted_next   = halted_reg;
        res_valid     = 1'b0;
        res           = '0;

        if (in_accept && !halted_reg) begin
            unique case (phase_reg)
                PH_HDR0: begin
                    fin_next    = in_byte[7];
                    rsv_next    = in_byte[6:4];
                    opcode_next = in_byte[3:0];
                    phase_next  = PH_HDR1;
                end
                PH_HDR1: begin
                    mask_bit_next = in_byte[7];
                    cnt_next      = 3'd0;
                    if (in_byte[6:0] == LEN7_EXT16) begin
                        len_next   = '0;
                        phase_next = PH_EXT16;
                    end else if (in_byte[6:0] == LEN7_EXT64) begin
                        len_next   = '0;
                        phase_next = PH_EXT64;
                    end else begin
                        len_next = {57'd0, in_byte[6:0]};
                        if (!in_byte[7]) begin
                            halted_next    = 1'b1;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NO_MASK;
                        end else begin
                            phase_next = PH_MASK;
                        end
                    end
                end
                PH_EXT16, PH_EXT64: begin
                    len_next = {len_reg[55:0], in_byte};
                    cnt_next = cnt_reg + 3'd1;
                    if ((phase_reg == PH_EXT16 && cnt_next == 3'd2) ||
                        (phase_reg == PH_EXT64 && cnt_next == 3'd0)) begin
                        cnt_next = 3'd0;
                        if (!mask_bit_reg) begin
                            halted_next    = 1'b1;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_NO_MASK;
                        end else begin
                            phase_next = PH_MASK;
                        end
                    end
                end
                PH_MASK: begin
                    key_next = {key_reg[23:0], in_byte};
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_next == 3'd4) begin
                        kidx_next  = 2'd0;
                        cpos_next  = 2'd0;
                        phase_next = PH_PAYLOAD;
                        if (rsv_reg != 3'd0) begin
                            halted_next    = 1'b1;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = ERR_RESERVED;
                        end else if (opcode_reg[3]) begin
                            if (ctrl_too_long || !fin_reg) begin
                                halted_next    = 1'b1;
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ctrl_too_long ? ERR_CTRL_TOO_LONG
                                                               : ERR_CTRL_FRAGMENT;
                            end else if (len_reg == 64'd0) begin
                                phase_next = PH_HDR0;
                                case (opcode_reg)
                                    OP_CLOSE: begin
                                        halted_next      = 1'b1;
                                        res_valid        = 1'b1;
                                        res.kind         = KIND_CLOSE_STATUS;
                                        res.last_flag    = 1'b1;
                                        res.close_status = STATUS_NO_CODE;
                                    end
                                    OP_PING: begin
                                        res_valid     = 1'b1;
                                        res.kind      = KIND_PING_EMPTY;
                                        res.last_flag = 1'b1;
                                    end
                                    OP_PONG: begin
                                    end
                                    default: begin
                                        halted_next    = 1'b1;
                                        res_valid      = 1'b1;
                                        res.kind       = KIND_ERROR;
                                        res.error_code = ERR_UNKNOWN_OPCODE;
                                    end
                                endcase
                            end
                        end else if ((opcode_reg == OP_CONT && !active_reg) ||
                                     (opcode_reg != OP_CONT && opcode_reg != OP_TEXT &&
                                      opcode_reg != OP_BINARY)) begin
                            halted_next    = 1'b1;
                            res_valid      = 1'b1;
                            res.kind       = KIND_ERROR;
                            res.error_code = (opcode_reg == OP_CONT) ? ERR_ORPHAN_CONT
                                                                     : ERR_UNKNOWN_OPCODE;
                        end else begin
                            if (opcode_reg != OP_CONT) begin
                                active_next = 1'b1;
                                binary_next = (opcode_reg == OP_BINARY);
                            end
                            if (too_big) begin
                                halted_next    = 1'b1;
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.error_code = ERR_TOO_BIG;
                            end else begin
                                total_next = total_reg + len_reg[LEN_W-1:0];
                                if (len_reg == 64'd0) begin
                                    phase_next = PH_HDR0;
                                    if (fin_reg) begin
                                        res_valid       = 1'b1;
                                        res.kind        = KIND_DATA_END;
                                        res.last_flag   = 1'b1;
                                        res.binary_flag = binary_next;
                                        active_next     = 1'b0;
                                        total_next      = '0;
                                    end
                                end
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    len_next  = len_reg - 64'd1;
                    kidx_next = kidx_reg + 2'd1;
                    if (cpos_reg != 2'd2) begin
                        cpos_next = cpos_reg + 2'd1;
                    end
                    if (last_byte) begin
                        phase_next = PH_HDR0;
                    end
                    if (!opcode_reg[3]) begin
                        res_valid       = 1'b1;
                        res.kind        = KIND_DATA;
                        res.data_byte   = plain;
                        res.binary_flag = binary_reg;
                        res.last_flag   = last_byte && fin_reg;
                        if (last_byte && fin_reg) begin
                            active_next = 1'b0;
                            total_next  = '0;
                        end
                    end else begin
                        case (opcode_reg)
                            OP_CLOSE: begin
                                if (last_byte) begin
                                    halted_next = 1'b1;
                                end
                                if (cpos_reg == 2'd0 && last_byte) begin
                                    res_valid      = 1'b1;
                                    res.kind       = KIND_ERROR;
                                    res.error_code = ERR_CLOSE_LEN_ONE;
                                end else if (cpos_reg == 2'd0) begin
                                    close_hi_next = plain;
                                end else if (cpos_reg == 2'd1) begin
                                    res_valid        = 1'b1;
                                    res.kind         = KIND_CLOSE_STATUS;
                                    res.last_flag    = last_byte;
                                    res.close_status = {close_hi_reg, plain};
                                end else begin
                                    res_valid     = 1'b1;
                                    res.kind      = KIND_CLOSE_REASON;
                                    res.data_byte = plain;
                                    res.last_flag = last_byte;
                                end
                            end
                            OP_PING: begin
                                res_valid     = 1'b1;
                                res.kind      = KIND_PING;
                                res.data_byte = plain;
                                res.last_flag = last_byte;
                            end
                            OP_PONG: begin
                            end
                            default: begin
                                if (last_byte) begin
                                    halted_next    = 1'b1;
                                    res_valid      = 1'b1;
                                    res.kind       = KIND_ERROR;
                                    res.error_code = ERR_UNKNOWN_OPCODE;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    phase_next = PH_HDR0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_HDR0;
            fin_reg      <= 1'b0;
            rsv_reg      <= '0;
            opcode_reg   <= '0;
            mask_bit_reg <= 1'b0;
            len_reg      <= '0;
            cnt_reg      <= '0;
            key_reg      <= '0;
            kidx_reg     <= '0;
            cpos_reg     <= '0;
            active_reg   <= 1'b0;
            binary_reg   <= 1'b0;
            total_reg    <= '0;
            close_hi_reg <= '0;
            halted_reg   <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            fin_reg      <= fin_next;
            rsv_reg      <= rsv_next;
            opcode_reg   <= opcode_next;
            mask_bit_reg <= mask_bit_next;
            len_reg      <= len_next;
            cnt_reg      <= cnt_next;
            key_reg      <= key_next;
            kidx_reg     <= kidx_next;
            cpos_reg     <= cpos_next;
            active_reg   <= active_next;
            binary_reg   <= binary_next;
            total_reg    <= total_next;
            close_hi_reg <= close_hi_next;
            halted_reg   <= halted_next;
        end
    end

endmodule

// File: rtl/core/wsfr_out_stage.sv
// Result register between the parser and the master stream port; it frees the input
// side whenever the held result is empty or being taken. Uses wsfr_pkg.
module wsfr_out_stage
    import wsfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  logic    res_valid,
    input  result_t res,
    input  logic    take,
    output logic    space,
    output logic    out_valid,
    output result_t out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg, res_next;

    assign space     = !valid_reg || take;
    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    always_comb begin
        valid_next = valid_reg;
        res_next   = res_reg;
        if (load) begin
            valid_next = res_valid;
            res_next   = res;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        res_reg <= res_next;
    end

endmodule

// File: rtl/core/websocket_frame_receiver_top.sv
// WebSocket client-to-server frame receiver: one received byte per transaction in,
// at most one result per byte out, registered in the cycle after the input transaction.
// Throughput is one byte per cycle while m_tready does not hold off the result register;
// the parser and the result register set that figure. Reset clears the parser and the
// result valid flag and sets max_len_reg to 65536. Depends on wsfr_pkg, wsfr_parser and wsfr_out_stage.
module websocket_frame_receiver_top
    import wsfr_pkg::*;
#(
    parameter int MSG_LEN_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] data_byte, [23:8] close_status, [27:24] error_code
    output logic [3:0]  m_tuser,   // [2:0] kind, [3] binary_flag
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    localparam int LEN_W = (MSG_LEN_BITS < 32) ? MSG_LEN_BITS : 32;

    logic [31:0] max_len_reg, max_len_next;
    logic        in_accept;
    logic        res_valid;
    result_t     res;
    result_t     out_res;

    assign cfg_ready    = 1'b1;
    assign max_len_next = (cfg_valid && cfg_ready) ? cfg_data : max_len_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= 32'd65536;
        end else begin
            max_len_reg <= max_len_next;
        end
    end

    assign in_accept = s_tvalid && s_tready;

    wsfr_parser #(
        .LEN_W(LEN_W)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .max_len   (max_len_reg[LEN_W-1:0]),
        .res_valid (res_valid),
        .res       (res)
    );

    wsfr_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (in_accept),
        .res_valid (res_valid),
        .res       (res),
        .take      (m_tready),
        .space     (s_tready),
        .out_valid (m_tvalid),
        .out_res   (out_res)
    );

    assign m_tdata = {4'd0, out_res.error_code, out_res.close_status, out_res.data_byte};
    assign m_tuser = {out_res.binary_flag, out_res.kind};
    assign m_tlast = out_res.last_flag;

endmodule
